// ===== hdl/slmd_pkg.sv =====
package slmd_pkg;

  // Largest payload the block will ever take, whatever the configured limit.
  localparam int unsigned MAX_PAYLOAD = 1024;

  // Field and state widths.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned LEN_W   = LIMIT_W + 1;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = LIMIT_W;

  // Hard cap on the payload limit, at the limit register's width.
  localparam logic [LIMIT_W-1:0] MAX_PAYLOAD_LIM = LIMIT_W'(MAX_PAYLOAD);

  // Register reset values.
  localparam logic [BYTE_W-1:0]  SYNC_FIRST_RST    = 8'd190;
  localparam logic [BYTE_W-1:0]  SYNC_SECOND_RST   = 8'd239;
  localparam logic [LIMIT_W-1:0] PAYLOAD_LIMIT_RST = 11'd1017;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST    = 2'd0,
    CFG_SYNC_SECOND   = 2'd1,
    CFG_PAYLOAD_LIMIT = 2'd2
  } slmd_cfg_idx_e;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_BAD   = 2'd2
  } slmd_kind_e;

  // Frame phases, one-hot.
  typedef enum logic [6:0] {
    PH_HUNT = 7'b0000001,
    PH_LEN0 = 7'b0000010,
    PH_LEN1 = 7'b0000100,
    PH_LEN2 = 7'b0001000,
    PH_LEN3 = 7'b0010000,
    PH_ID   = 7'b0100000,
    PH_DATA = 7'b1000000
  } slmd_phase_e;

  // Current register contents.
  typedef struct packed {
    logic [BYTE_W-1:0]  sync_first;
    logic [BYTE_W-1:0]  sync_second;
    logic [LIMIT_W-1:0] payload_limit;
  } slmd_cfg_t;

  // One result item.
  typedef struct packed {
    slmd_kind_e        kind;
    logic [BYTE_W-1:0] message_id;
    logic [BYTE_W-1:0] data_byte;
    logic              first_of_message;
    logic              last_of_message;
  } slmd_result_t;

endpackage

// ===== hdl/slmd_cfg_regs.sv =====
module slmd_cfg_regs
  import slmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output slmd_cfg_t             cfg_o
);

  slmd_cfg_t cfg_q, cfg_d;

  // Decode the write; an index beyond the register list is dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SYNC_FIRST:    cfg_d.sync_first    = cfg_data_i[BYTE_W-1:0];
        CFG_SYNC_SECOND:   cfg_d.sync_second   = cfg_data_i[BYTE_W-1:0];
        CFG_PAYLOAD_LIMIT: cfg_d.payload_limit = cfg_data_i[LIMIT_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first    <= SYNC_FIRST_RST;
      cfg_q.sync_second   <= SYNC_SECOND_RST;
      cfg_q.payload_limit <= PAYLOAD_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/slmd_in_reg.sv =====
module slmd_in_reg
  import slmd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic              take_i,
  output logic              fire_o,
  output logic [BYTE_W-1:0] byte_o
);

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q, byte_d;

  // The held byte leaves whenever the result side can take its outcome.
  assign fire_o     = valid_q & take_i;
  assign in_stall_o = valid_q & ~take_i;
  assign byte_o     = byte_q;

  // Refill the input register whenever it is empty or being drained.
  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        byte_d = rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

// ===== hdl/slmd_core.sv =====
module slmd_core
  import slmd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slmd_cfg_t         cfg_i,
  input  logic              fire_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic              res_valid_o,
  output slmd_result_t      res_o
);

  slmd_phase_e        phase_q, phase_d;
  logic [BYTE_W-1:0]  prev_q, prev_d;
  logic               prev_valid_q, prev_valid_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               len_hi_q, len_hi_d;
  logic [LIMIT_W-1:0] rem_q, rem_d;
  logic [BYTE_W-1:0]  id_q, id_d;
  logic               started_q, started_d;

  logic [LIMIT_W-1:0] lim;
  logic [LEN_W-1:0]   lim_plus1;
  logic [LEN_W-1:0]   len_minus1;
  logic               len_hi_full;
  logic               len_bad;
  logic [LIMIT_W-1:0] rem_next;

  // Length check against the smaller of the configured and hard limits.
  // Only the low twelve length bits are kept; any higher bit set is a bad length.
  assign lim         = (cfg_i.payload_limit > MAX_PAYLOAD_LIM) ? MAX_PAYLOAD_LIM
                                                               : cfg_i.payload_limit;
  assign lim_plus1   = {1'b0, lim} + LEN_W'(1);
  assign len_minus1  = len_q - LEN_W'(1);
  assign len_hi_full = len_hi_q | (byte_i != '0);
  assign len_bad     = len_hi_full | (len_q == '0) | (len_q > lim_plus1);
  assign rem_next    = (rem_q != '0) ? rem_q - LIMIT_W'(1) : '0;

  // Phase machine: one received byte per firing.
  always_comb begin
    phase_d      = phase_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    len_d        = len_q;
    len_hi_d     = len_hi_q;
    rem_d        = rem_q;
    id_d         = id_q;
    started_d    = started_q;
    res_valid_o  = 1'b0;
    res_o        = '{kind: KIND_BYTE, message_id: '0, data_byte: '0,
                    first_of_message: 1'b0, last_of_message: 1'b0};
    if (fire_i) begin
      unique case (phase_q)
        PH_LEN0: begin
          len_d    = {{(LEN_W-BYTE_W){1'b0}}, byte_i};
          len_hi_d = 1'b0;
          phase_d  = PH_LEN1;
        end
        PH_LEN1: begin
          len_d[LEN_W-1:BYTE_W] = byte_i[LEN_W-BYTE_W-1:0];
          len_hi_d = len_hi_q | (byte_i[BYTE_W-1:LEN_W-BYTE_W] != '0);
          phase_d  = PH_LEN2;
        end
        PH_LEN2: begin
          len_hi_d = len_hi_full;
          phase_d  = PH_LEN3;
        end
        PH_LEN3: begin
          len_hi_d = len_hi_full;
          if (len_bad) begin
            phase_d      = PH_HUNT;
            prev_d       = '0;
            prev_valid_d = 1'b0;
            res_valid_o  = 1'b1;
            res_o.kind   = KIND_BAD;
          end else begin
            rem_d   = len_minus1[LIMIT_W-1:0];
            phase_d = PH_ID;
          end
        end
        PH_ID: begin
          id_d      = byte_i;
          started_d = 1'b0;
          if (rem_q == '0) begin
            phase_d               = PH_HUNT;
            prev_d                = '0;
            prev_valid_d          = 1'b0;
            res_valid_o           = 1'b1;
            res_o.kind            = KIND_EMPTY;
            res_o.message_id      = byte_i;
            res_o.last_of_message = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          res_valid_o            = 1'b1;
          res_o.kind             = KIND_BYTE;
          res_o.message_id       = id_q;
          res_o.data_byte        = byte_i;
          res_o.first_of_message = ~started_q;
          res_o.last_of_message  = (rem_q <= LIMIT_W'(1));
          started_d              = 1'b1;
          rem_d                  = rem_next;
          if (rem_next == '0) begin
            phase_d      = PH_HUNT;
            prev_d       = '0;
            prev_valid_d = 1'b0;
          end
        end
        default: begin
          // Hunting: a failed match makes this byte the next candidate.
          if (prev_valid_q && (prev_q == cfg_i.sync_first) &&
              (byte_i == cfg_i.sync_second)) begin
            prev_d       = '0;
            prev_valid_d = 1'b0;
            phase_d      = PH_LEN0;
          end else begin
            prev_d       = byte_i;
            prev_valid_d = 1'b1;
            phase_d      = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      len_q        <= '0;
      len_hi_q     <= 1'b0;
      rem_q        <= '0;
      id_q         <= '0;
      started_q    <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      prev_q       <= prev_d;
      prev_valid_q <= prev_valid_d;
      len_q        <= len_d;
      len_hi_q     <= len_hi_d;
      rem_q        <= rem_d;
      id_q         <= id_d;
      started_q    <= started_d;
    end
  end

  // A result only comes out of a byte that is being processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid_o |-> fire_i)
    else $error("result without a processed byte");

  // A dropped frame is only decided on the last length byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_BAD) |-> phase_q == PH_LEN3)
    else $error("bad length reported outside the length field");

  // The payload phase always has at least one byte left to take.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> rem_q != '0)
    else $error("payload phase with no bytes remaining");

  // The final payload byte sends the block back to hunting with no candidate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && phase_q == PH_DATA && rem_q == LIMIT_W'(1))
      |=> (phase_q == PH_HUNT && !prev_valid_q))
    else $error("frame end did not return to hunting");

endmodule

// ===== hdl/slmd_out_reg.sv =====
module slmd_out_reg
  import slmd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         res_valid_i,
  input  slmd_result_t res_i,
  output logic         take_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output slmd_result_t res_o
);

  logic         valid_q, valid_d;
  slmd_result_t res_q, res_d;

  // A new outcome may be produced when the register is empty or being drained.
  assign take_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (take_o) begin
      valid_d = res_valid_i;
      if (res_valid_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/sync_length_message_deframer_unit.sv =====
// Byte-stream deframer: hunts for a two-byte sync header, reads a 32-bit
// little-endian length (ID byte plus payload), the message ID, then the
// payload. Each payload byte comes out with its ID and first/last marks; an
// empty payload gives one marker result, and a zero or over-limit length
// gives one bad-length result before hunting resumes. The block takes one
// byte per cycle while the result side does not stall: each byte passes
// through an input register, one pass of the phase logic and a result
// register, which offers the result on the outputs. A stall on the result
// side holds the result register and, while a byte waits in the input
// register, the input side. Register writes take effect on the next byte.
module sync_length_message_deframer_unit
  import slmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [BYTE_W-1:0]     rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     kind_o,
  output logic [BYTE_W-1:0]     message_id_o,
  output logic [BYTE_W-1:0]     data_byte_o,
  output logic                  first_of_message_o,
  output logic                  last_of_message_o
);

  slmd_cfg_t         cfg;
  logic              take;
  logic              fire;
  logic [BYTE_W-1:0] byte_q;
  logic              res_valid;
  slmd_result_t      res;
  slmd_result_t      res_out;

  // Register file.
  slmd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register.
  slmd_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .fire_o     (fire),
    .byte_o     (byte_q)
  );

  // Frame phase machine.
  slmd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (fire),
    .byte_i      (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register.
  slmd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign kind_o             = res_out.kind;
  assign message_id_o       = res_out.message_id;
  assign data_byte_o        = res_out.data_byte;
  assign first_of_message_o = res_out.first_of_message;
  assign last_of_message_o  = res_out.last_of_message;

endmodule
